### design/rk4bo_pkg.sv
package rk4bo_pkg;

   // Field widths fixed by the word formats.
   localparam int FRAC_BITS  = 31;
   localparam int CONC_BITS  = 32;
   localparam int TICK_BITS  = 32;
   localparam int RATE_BITS  = 32;
   localparam int AMT_BITS   = 32;
   localparam int LIMIT_BITS = 20;
   localparam int OUT_TIME_BITS = 48;
   localparam int OUT_COUNT_BITS = 20;
   localparam int STATUS_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Serial multiplier: 64-bit multiplicand, 32-bit multiplier, one bit a cycle.
   localparam int MUL_A_BITS = 64;
   localparam int MUL_B_BITS = 32;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS);

   // Serial restoring divider: 64-bit dividend, 32-bit divisor.
   localparam int DIV_N_BITS = 64;
   localparam int DIV_D_BITS = 32;
   localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS);

   localparam logic [FRAC_BITS-1:0] ONE_Q30 = 31'h4000_0000;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BOUND = 2'd2;

   // Slopes and their weighted sum.
   typedef logic signed [39:0] slope_type;

endpackage

### design/rk4bo_if.sv
interface rk4bo_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [rk4bo_pkg::FRAC_BITS-1:0]     initial_fraction;
   logic [rk4bo_pkg::CONC_BITS-1:0]     concentration;
   logic [rk4bo_pkg::TICK_BITS-1:0]     step_ticks;

   modport source (output valid, kind, initial_fraction, concentration, step_ticks,
                   input ready);
   modport sink   (input valid, kind, initial_fraction, concentration, step_ticks,
                   output ready);
endinterface

interface rk4bo_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [rk4bo_pkg::OUT_TIME_BITS-1:0]    sample_time;
   logic [rk4bo_pkg::FRAC_BITS-1:0]        bound_now;
   logic [rk4bo_pkg::FRAC_BITS-1:0]        peak_bound;
   logic                                   crossed;
   logic [rk4bo_pkg::OUT_TIME_BITS-1:0]    crossing_time;
   logic [rk4bo_pkg::OUT_COUNT_BITS-1:0]   steps_done;
   logic [rk4bo_pkg::AMT_BITS-1:0]         bound_amount;
   logic [rk4bo_pkg::AMT_BITS-1:0]         free_amount;
   logic [rk4bo_pkg::STATUS_BITS-1:0]      status;

   modport source (output valid, sample_time, bound_now, peak_bound, crossed,
                   crossing_time, steps_done, bound_amount, free_amount, status,
                   input ready);
   modport sink   (input valid, sample_time, bound_now, peak_bound, crossed,
                   crossing_time, steps_done, bound_amount, free_amount, status,
                   output ready);
endinterface

### design/rk4bo_mul.sv
module rk4bo_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rk4bo_pkg::MUL_A_BITS-1:0]    a,
   input  logic [rk4bo_pkg::MUL_B_BITS-1:0]    b,
   output logic                                done,
   output logic [rk4bo_pkg::MUL_P_BITS-1:0]    prod
);

   logic                                  busy_ff;
   logic                                  done_ff;
   logic [rk4bo_pkg::MUL_CNT_BITS-1:0]    cnt_ff;
   logic [rk4bo_pkg::MUL_A_BITS-1:0]      a_ff;
   logic [rk4bo_pkg::MUL_B_BITS-1:0]      b_ff;
   logic [rk4bo_pkg::MUL_P_BITS-1:0]      acc_ff;
   logic [rk4bo_pkg::MUL_A_BITS:0]        add_in;
   logic [rk4bo_pkg::MUL_P_BITS-1:0]      acc_in;

   localparam logic [rk4bo_pkg::MUL_CNT_BITS-1:0] LAST =
      rk4bo_pkg::MUL_CNT_BITS'(rk4bo_pkg::MUL_B_BITS - 1);

   // Add the multiplicand into the upper part, then shift the whole word right.
   always_comb begin
      add_in = {1'b0, acc_ff[rk4bo_pkg::MUL_P_BITS-1:rk4bo_pkg::MUL_B_BITS]} +
               {1'b0, (b_ff[0] ? a_ff : '0)};
      acc_in = {add_in, acc_ff[rk4bo_pkg::MUL_B_BITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         b_ff   <= b_ff >> 1;
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### design/rk4bo_div.sv
module rk4bo_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rk4bo_pkg::DIV_N_BITS-1:0]    dividend,
   input  logic [rk4bo_pkg::DIV_D_BITS-1:0]    divisor,
   output logic                                done,
   output logic [rk4bo_pkg::DIV_N_BITS-1:0]    quotient
);

   logic                                  busy_ff;
   logic                                  done_ff;
   logic [rk4bo_pkg::DIV_CNT_BITS-1:0]    cnt_ff;
   logic [rk4bo_pkg::DIV_D_BITS-1:0]      d_ff;
   logic [rk4bo_pkg::DIV_D_BITS-1:0]      rem_ff;
   logic [rk4bo_pkg::DIV_N_BITS-1:0]      q_ff;
   logic [rk4bo_pkg::DIV_D_BITS:0]        shifted;
   logic [rk4bo_pkg::DIV_D_BITS:0]        diff;
   logic                                  fits;
   logic [rk4bo_pkg::DIV_D_BITS-1:0]      rem_in;

   localparam logic [rk4bo_pkg::DIV_CNT_BITS-1:0] LAST =
      rk4bo_pkg::DIV_CNT_BITS'(rk4bo_pkg::DIV_N_BITS - 1);

   // One quotient bit a cycle; the remainder always stays below a nonzero divisor.
   always_comb begin
      shifted = {rem_ff, q_ff[rk4bo_pkg::DIV_N_BITS-1]};
      diff    = shifted - {1'b0, d_ff};
      fits    = shifted >= {1'b0, d_ff};
      rem_in  = fits ? diff[rk4bo_pkg::DIV_D_BITS-1:0]
                     : shifted[rk4bo_pkg::DIV_D_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff   <= divisor;
         rem_ff <= '0;
         q_ff   <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[rk4bo_pkg::DIV_N_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### design/rk4_binding_occupancy_step.sv
// Channel   Direction  Word
// req_chan  in         kind, initial_fraction, concentration, step_ticks
// rsp_chan  out        sample_time ... status, one word per request word
// csr_*     in         csr_wen, csr_index, csr_wdata; one register per write
//
// The time a word takes is set by the shared multiplier, which retires one
// multiplier bit a cycle (twelve or thirteen products a step), and by the
// restoring divider used for the division by six and the crossing.
// Reset is synchronous and restores the register defaults and a cleared state.
// A request word is taken only when the block is idle; a finished word waits in
// the output register while the next request is accepted and worked on.
module rk4_binding_occupancy_step #(
   parameter int TIME_BITS       = 48,
   parameter int STEP_COUNT_BITS = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   rk4bo_req_if.sink                               req_chan,
   rk4bo_rsp_if.source                             rsp_chan,
   input  logic                                    csr_wen,
   input  logic [rk4bo_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rk4bo_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam logic [rk4bo_pkg::CSR_INDEX_BITS-1:0] REG_ASSOC  = 3'd0;
   localparam logic [rk4bo_pkg::CSR_INDEX_BITS-1:0] REG_DISSOC = 3'd1;
   localparam logic [rk4bo_pkg::CSR_INDEX_BITS-1:0] REG_THRESH = 3'd2;
   localparam logic [rk4bo_pkg::CSR_INDEX_BITS-1:0] REG_LIMIT  = 3'd3;
   localparam logic [rk4bo_pkg::CSR_INDEX_BITS-1:0] REG_TOTAL  = 3'd4;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_MP   = 4'd2;
   localparam logic [3:0] S_MF   = 4'd3;
   localparam logic [3:0] S_MD   = 4'd4;
   localparam logic [3:0] S_MA   = 4'd5;
   localparam logic [3:0] S_MB   = 4'd6;
   localparam logic [3:0] S_KUP  = 4'd7;
   localparam logic [3:0] S_D6   = 4'd8;
   localparam logic [3:0] S_CHK  = 4'd9;
   localparam logic [3:0] S_MN   = 4'd10;
   localparam logic [3:0] S_DC   = 4'd11;
   localparam logic [3:0] S_UPD  = 4'd12;
   localparam logic [3:0] S_MBND = 4'd13;
   localparam logic [3:0] S_OUT  = 4'd14;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic signed [35:0] ONE_S36 = 36'sd1073741824;
   localparam rk4bo_pkg::slope_type ONE_S40   = 40'sd1073741824;
   localparam rk4bo_pkg::slope_type CAP_S40   = 40'sd4294967296;
   localparam rk4bo_pkg::slope_type NCAP_S40  = -40'sd4294967296;
   localparam rk4bo_pkg::slope_type MINUS_ONE = -40'sd1;
   localparam rk4bo_pkg::slope_type ONE_P1    = 40'sd1073741825;

   // Configuration registers.
   logic [rk4bo_pkg::RATE_BITS-1:0]  assoc_ff;
   logic [rk4bo_pkg::RATE_BITS-1:0]  dissoc_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]  thr_ff;
   logic [rk4bo_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [rk4bo_pkg::AMT_BITS-1:0]   total_ff;

   // Integration state.
   logic [rk4bo_pkg::FRAC_BITS-1:0]  occ_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]  peak_ff;
   logic [TIME_BITS-1:0]             elapsed_ff;
   logic                             crossed_ff;
   logic [TIME_BITS-1:0]             tick_ff;
   logic [STEP_COUNT_BITS-1:0]       count_ff;
   logic                             failed_ff;
   logic [rk4bo_pkg::STATUS_BITS-1:0] held_ff;

   // Sequencer and working registers.
   logic [3:0]                       state_ff;
   logic                             launched_ff;
   logic                             kind_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]  init_ff;
   logic [rk4bo_pkg::CONC_BITS-1:0]  conc_ff;
   logic [rk4bo_pkg::TICK_BITS-1:0]  h_ff;
   logic [63:0]                      pw_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]  ca_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]  cd_ff;
   logic signed [33:0]               x_ff;
   logic [1:0]                       stage_ff;
   rk4bo_pkg::slope_type             t1_ff;
   rk4bo_pkg::slope_type             k_ff;
   rk4bo_pkg::slope_type             acc_ff;
   rk4bo_pkg::slope_type             next_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]  nextc_ff;
   logic [63:0]                      num_ff;
   logic [rk4bo_pkg::AMT_BITS-1:0]   bound_ff;
   logic [rk4bo_pkg::STATUS_BITS-1:0] status_ff;

   // Output register.
   logic                                   rsp_valid_ff;
   logic [rk4bo_pkg::OUT_TIME_BITS-1:0]    rsp_time_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]        rsp_bound_ff;
   logic [rk4bo_pkg::FRAC_BITS-1:0]        rsp_peak_ff;
   logic                                   rsp_crossed_ff;
   logic [rk4bo_pkg::OUT_TIME_BITS-1:0]    rsp_ctime_ff;
   logic [rk4bo_pkg::OUT_COUNT_BITS-1:0]   rsp_steps_ff;
   logic [rk4bo_pkg::AMT_BITS-1:0]         rsp_bamt_ff;
   logic [rk4bo_pkg::AMT_BITS-1:0]         rsp_famt_ff;
   logic [rk4bo_pkg::STATUS_BITS-1:0]      rsp_status_ff;

   // Shared arithmetic units.
   logic                                  mul_start;
   logic [rk4bo_pkg::MUL_A_BITS-1:0]      mul_a;
   logic [rk4bo_pkg::MUL_B_BITS-1:0]      mul_b;
   logic                                  mul_done;
   logic [rk4bo_pkg::MUL_P_BITS-1:0]      mul_prod;
   logic                                  div_start;
   logic [rk4bo_pkg::DIV_N_BITS-1:0]      div_n;
   logic [rk4bo_pkg::DIV_D_BITS-1:0]      div_d;
   logic                                  div_done;
   logic [rk4bo_pkg::DIV_N_BITS-1:0]      div_q;

   // Combinational helpers.
   logic                                  req_accept;
   logic [rk4bo_pkg::FRAC_BITS-1:0]       init_sat;
   logic signed [35:0]                    x_ext;
   logic signed [35:0]                    omx;
   logic                                  omx_neg;
   logic [35:0]                           omx_mag;
   logic                                  x_neg;
   logic [35:0]                           x_mag;
   rk4bo_pkg::slope_type                  mq;
   rk4bo_pkg::slope_type                  k_weighted;
   rk4bo_pkg::slope_type                  k_adj;
   rk4bo_pkg::slope_type                  k_half;
   rk4bo_pkg::slope_type                  stage_base;
   rk4bo_pkg::slope_type                  stage_sum;
   rk4bo_pkg::slope_type                  stage_sat;
   rk4bo_pkg::slope_type                  occ_s40;
   logic                                  acc_neg;
   rk4bo_pkg::slope_type                  acc_mag;
   rk4bo_pkg::slope_type                  q6;
   logic                                  out_of_range;
   logic [rk4bo_pkg::FRAC_BITS-1:0]       next_clamp;
   logic                                  cross_now;
   logic [63:0]                           t64;
   logic [TIME_BITS:0]                    esum;
   logic [63:0]                           elapsed64;
   logic [63:0]                           tick64;
   logic [31:0]                           count32;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      init_sat = (init_ff > rk4bo_pkg::ONE_Q30) ? rk4bo_pkg::ONE_Q30 : init_ff;

      // Slope arguments: 1 - x and x in sign and magnitude.
      x_ext   = 36'(x_ff);
      omx     = ONE_S36 - x_ext;
      omx_neg = omx[35];
      omx_mag = $unsigned(omx_neg ? -omx : omx);
      x_neg   = x_ff[33];
      x_mag   = $unsigned(x_neg ? -x_ext : x_ext);
      mq      = $signed(mul_prod[69:30]);

      // Weighted sum and the next stage argument.
      k_weighted = (stage_ff == 2'd1 || stage_ff == 2'd2) ? (k_ff <<< 1) : k_ff;
      k_adj      = k_ff + $signed({39'd0, k_ff[39]});
      k_half     = k_adj >>> 1;
      stage_base = (stage_ff == 2'd2) ? k_ff : k_half;
      occ_s40    = $signed({9'd0, occ_ff});
      stage_sum  = occ_s40 + stage_base;
      if (stage_sum > CAP_S40) begin
         stage_sat = CAP_S40;
      end else if (stage_sum < NCAP_S40) begin
         stage_sat = NCAP_S40;
      end else begin
         stage_sat = stage_sum;
      end

      // Division by six is done on the magnitude so that it truncates to zero.
      acc_neg = acc_ff[39];
      acc_mag = acc_neg ? -acc_ff : acc_ff;
      q6      = $signed(div_q[39:0]);

      out_of_range = (next_ff < MINUS_ONE) || (next_ff > ONE_P1);
      if (next_ff[39]) begin
         next_clamp = '0;
      end else if (next_ff > ONE_S40) begin
         next_clamp = rk4bo_pkg::ONE_Q30;
      end else begin
         next_clamp = next_ff[rk4bo_pkg::FRAC_BITS-1:0];
      end
      cross_now = !crossed_ff && (occ_ff < thr_ff) && (next_clamp >= thr_ff);

      // The crossing sum wraps at 64 bits before the time saturation.
      t64       = 64'(elapsed_ff) + div_q;
      esum      = (TIME_BITS+1)'(elapsed_ff) + (TIME_BITS+1)'(h_ff);
      elapsed64 = 64'(elapsed_ff);
      tick64    = 64'(tick_ff);
      count32   = 32'(count_ff);
   end

   // Operand selection for the shared units.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = '0;
      div_d = '0;
      unique case (state_ff)
         S_MP: begin
            mul_a = 64'(assoc_ff);
            mul_b = conc_ff;
         end
         S_MF: begin
            mul_a = pw_ff;
            mul_b = h_ff;
         end
         S_MD: begin
            mul_a = 64'(dissoc_ff);
            mul_b = h_ff;
         end
         S_MA: begin
            mul_a = 64'(omx_mag);
            mul_b = 32'(ca_ff);
         end
         S_MB: begin
            mul_a = 64'(x_mag);
            mul_b = 32'(cd_ff);
         end
         S_MN: begin
            mul_a = 64'(thr_ff - occ_ff);
            mul_b = h_ff;
         end
         S_MBND: begin
            mul_a = 64'(occ_ff);
            mul_b = total_ff;
         end
         S_D6: begin
            div_n = 64'($unsigned(acc_mag));
            div_d = 32'd6;
         end
         S_DC: begin
            div_n = num_ff;
            div_d = 32'(nextc_ff - occ_ff);
         end
         default: begin
         end
      endcase
      mul_start = !launched_ff &&
                  (state_ff inside {S_MP, S_MF, S_MD, S_MA, S_MB, S_MN, S_MBND});
      div_start = !launched_ff && (state_ff inside {S_D6, S_DC});
   end

   rk4bo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   rk4bo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         assoc_ff  <= '0;
         dissoc_ff <= '0;
         thr_ff    <= 31'd536870912;
         limit_ff  <= 20'd1000000;
         total_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_ASSOC:  assoc_ff  <= csr_wdata;
            REG_DISSOC: dissoc_ff <= csr_wdata;
            REG_THRESH: thr_ff    <= csr_wdata[rk4bo_pkg::FRAC_BITS-1:0];
            REG_LIMIT:  limit_ff  <= csr_wdata[rk4bo_pkg::LIMIT_BITS-1:0];
            REG_TOTAL:  total_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         occ_ff       <= '0;
         peak_ff      <= '0;
         elapsed_ff   <= '0;
         crossed_ff   <= 1'b0;
         tick_ff      <= '0;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         held_ff      <= rk4bo_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_start || div_start) begin
            launched_ff <= 1'b1;
         end else if (mul_done || div_done) begin
            launched_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  kind_ff  <= req_chan.kind;
                  init_ff  <= req_chan.initial_fraction;
                  conc_ff  <= req_chan.concentration;
                  h_ff     <= req_chan.step_ticks;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               if (!kind_ff) begin
                  occ_ff     <= init_sat;
                  peak_ff    <= init_sat;
                  elapsed_ff <= '0;
                  count_ff   <= '0;
                  failed_ff  <= 1'b0;
                  held_ff    <= rk4bo_pkg::STATUS_OK;
                  crossed_ff <= (init_sat >= thr_ff);
                  tick_ff    <= '0;
                  status_ff  <= rk4bo_pkg::STATUS_OK;
                  state_ff   <= S_MBND;
               end else if (failed_ff) begin
                  status_ff <= held_ff;
                  state_ff  <= S_MBND;
               end else if (count32 >= 32'(limit_ff)) begin
                  failed_ff <= 1'b1;
                  held_ff   <= rk4bo_pkg::STATUS_BOUND;
                  status_ff <= rk4bo_pkg::STATUS_BOUND;
                  state_ff  <= S_MBND;
               end else begin
                  x_ff     <= $signed({3'd0, occ_ff});
                  stage_ff <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= S_MP;
               end
            end
            S_MP: begin
               if (mul_done) begin
                  pw_ff    <= mul_prod[63:0];
                  state_ff <= S_MF;
               end
            end
            S_MF: begin
               if (mul_done) begin
                  ca_ff    <= (|mul_prod[95:48]) ? rk4bo_pkg::ONE_Q30
                                                 : {1'b0, mul_prod[47:18]};
                  state_ff <= S_MD;
               end
            end
            S_MD: begin
               if (mul_done) begin
                  cd_ff    <= (|mul_prod[63:32]) ? rk4bo_pkg::ONE_Q30
                                                 : {1'b0, mul_prod[31:2]};
                  state_ff <= S_MA;
               end
            end
            S_MA: begin
               if (mul_done) begin
                  t1_ff    <= omx_neg ? -mq : mq;
                  state_ff <= S_MB;
               end
            end
            S_MB: begin
               if (mul_done) begin
                  k_ff     <= t1_ff - (x_neg ? -mq : mq);
                  state_ff <= S_KUP;
               end
            end
            S_KUP: begin
               acc_ff <= acc_ff + k_weighted;
               if (stage_ff == 2'd3) begin
                  state_ff <= S_D6;
               end else begin
                  x_ff     <= stage_sat[33:0];
                  stage_ff <= stage_ff + 2'd1;
                  state_ff <= S_MA;
               end
            end
            S_D6: begin
               if (div_done) begin
                  next_ff  <= occ_s40 + (acc_neg ? -q6 : q6);
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               nextc_ff <= next_clamp;
               if (out_of_range) begin
                  failed_ff <= 1'b1;
                  held_ff   <= rk4bo_pkg::STATUS_RANGE;
                  status_ff <= rk4bo_pkg::STATUS_RANGE;
                  state_ff  <= S_MBND;
               end else if (cross_now) begin
                  state_ff <= S_MN;
               end else begin
                  state_ff <= S_UPD;
               end
            end
            S_MN: begin
               if (mul_done) begin
                  num_ff   <= mul_prod[63:0];
                  state_ff <= S_DC;
               end
            end
            S_DC: begin
               if (div_done) begin
                  tick_ff    <= ((t64 >> TIME_BITS) != 64'd0) ? TIME_MAX
                                                              : t64[TIME_BITS-1:0];
                  crossed_ff <= 1'b1;
                  state_ff   <= S_UPD;
               end
            end
            S_UPD: begin
               elapsed_ff <= esum[TIME_BITS] ? TIME_MAX : esum[TIME_BITS-1:0];
               count_ff   <= count_ff + 1'b1;
               occ_ff     <= nextc_ff;
               if (nextc_ff > peak_ff) begin
                  peak_ff <= nextc_ff;
               end
               status_ff <= rk4bo_pkg::STATUS_OK;
               state_ff  <= S_MBND;
            end
            S_MBND: begin
               if (mul_done) begin
                  bound_ff <= mul_prod[61:30];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // The output register is loaded once the previous word has left.
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_time_ff    <= elapsed64[rk4bo_pkg::OUT_TIME_BITS-1:0];
                  rsp_bound_ff   <= occ_ff;
                  rsp_peak_ff    <= peak_ff;
                  rsp_crossed_ff <= crossed_ff;
                  rsp_ctime_ff   <= crossed_ff ? tick64[rk4bo_pkg::OUT_TIME_BITS-1:0] : '0;
                  rsp_steps_ff   <= count32[rk4bo_pkg::OUT_COUNT_BITS-1:0];
                  rsp_bamt_ff    <= bound_ff;
                  rsp_famt_ff    <= total_ff - bound_ff;
                  rsp_status_ff  <= status_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_time   = rsp_time_ff;
   assign rsp_chan.bound_now     = rsp_bound_ff;
   assign rsp_chan.peak_bound    = rsp_peak_ff;
   assign rsp_chan.crossed       = rsp_crossed_ff;
   assign rsp_chan.crossing_time = rsp_ctime_ff;
   assign rsp_chan.steps_done    = rsp_steps_ff;
   assign rsp_chan.bound_amount  = rsp_bamt_ff;
   assign rsp_chan.free_amount   = rsp_famt_ff;
   assign rsp_chan.status        = rsp_status_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= rk4bo_pkg::ONE_Q30)
      else $error("occupancy above one");

   a_peak_ge_occ: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= occ_ff)
      else $error("peak below current occupancy");

   a_failed_code: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (held_ff == rk4bo_pkg::STATUS_RANGE || held_ff == rk4bo_pkg::STATUS_BOUND))
      else $error("sticky error without an error code");

   a_tick_clear: assert property (@(posedge clock) disable iff (reset)
      !crossed_ff |-> (tick_ff == '0))
      else $error("crossing tick set before a crossing");

endmodule
